/* rtl/ddd_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, constants, stage-enable type and month table for the
// date difference core. No dependencies.
package ddd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int N_W      = 15;    // year plus offset, up to 16782
    localparam int DAYNUM_W = 23;    // unsigned day number, below 2^23
    localparam int DIFF_W   = 24;    // signed difference of two day numbers
    localparam int OUT_W    = 23;
    localparam int MDAYS_W  = 9;     // cumulative days before a month, up to 334

    // Offset of 400 years less one; cancels in the difference.
    localparam logic [N_W-1:0] YEAR_OFFSET = 15'd399;

    // x / 100 == (x * 5243) >> 19, exact for x below 43690.
    localparam int PROD_W      = 28;
    localparam int RECIP_SHIFT = 19;
    localparam logic [PROD_W-1:0] RECIP_100 = 28'd5243;
    localparam int Q100_W = 8;       // n / 100 and y / 100, at most 167
    localparam int Q400_W = 6;       // n / 400, at most 41

    localparam logic [DAYNUM_W-1:0] DAYS_PER_YEAR = 23'd365;
    localparam logic [2*Q100_W-1:0] CENTURY       = 16'd100;
    localparam logic [MONTH_W-1:0]  MARCH         = 4'd3;

    localparam logic signed [DIFF_W-1:0] OUT_MAX = 24'sd4194303;
    localparam logic signed [DIFF_W-1:0] OUT_MIN = -24'sd4194304;

    // Load enables of the three day-number stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // Days before the first of a month; month 0 reads as January and
    // anything above twelve as December.
    function automatic logic [MDAYS_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
        logic [MDAYS_W-1:0] days;
        case (month)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            default: days = 9'd334;
        endcase
        return days;
    endfunction

endpackage

/* rtl/date_difference_days_core.sv */
`timescale 1ns / 1ps
// Top level of the Gregorian date difference core.
// Depends on ddd_pkg and ddd_daynum.
//
// Takes two Gregorian dates and an inclusive flag per beat and returns the
// signed day count from the first date to the second (negative when the
// first date is later). With inclusive set the magnitude grows by one and
// keeps its sign, so equal dates give 1. Day values are not checked against
// the month length; month 0 counts as January and months above 12 as
// December; the result saturates to the 23-bit signed range. Throughput is
// one beat per clock while m_ready does not stall the output; a beat passes
// three day-number stages, one subtract stage and one adjust/saturate stage
// that is also the output register. Each stage holds its own valid bit and
// loads whenever it is empty or its successor moves, so bubbles close up and
// the input keeps taking beats while a finished result waits on m_ready,
// until all five stages hold a beat.
module date_difference_days_core (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ddd_pkg::YEAR_W-1:0]         s_first_year,
    input  logic [ddd_pkg::MONTH_W-1:0]        s_first_month,
    input  logic [ddd_pkg::DAY_W-1:0]          s_first_day,
    input  logic [ddd_pkg::YEAR_W-1:0]         s_second_year,
    input  logic [ddd_pkg::MONTH_W-1:0]        s_second_month,
    input  logic [ddd_pkg::DAY_W-1:0]          s_second_day,
    input  logic                               s_inclusive,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ddd_pkg::OUT_W-1:0]   m_day_difference
);

    // Stage valid bits: 1..3 day numbers, 4 difference, 5 output.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    ddd_pkg::stage_en_t dn_en;

    // A stage loads when it is empty or its contents move on this cycle.
    assign en5 = !v5_reg || m_ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign dn_en.s1 = en1;
    assign dn_en.s2 = en2;
    assign dn_en.s3 = en3;

    assign s_ready = en1;
    assign m_valid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Day numbers of both dates, in lockstep.
    logic [ddd_pkg::DAYNUM_W-1:0] first_num, second_num;

    ddd_daynum u_first (
        .aclk    (aclk),
        .en      (dn_en),
        .year    (s_first_year),
        .month   (s_first_month),
        .day     (s_first_day),
        .day_num (first_num)
    );

    ddd_daynum u_second (
        .aclk    (aclk),
        .en      (dn_en),
        .year    (s_second_year),
        .month   (s_second_month),
        .day     (s_second_day),
        .day_num (second_num)
    );

    // Inclusive flag rides alongside the day-number stages.
    logic incl1_reg, incl2_reg, incl3_reg, incl4_reg;

    always_ff @(posedge aclk) begin
        if (en1) incl1_reg <= s_inclusive;
        if (en2) incl2_reg <= incl1_reg;
        if (en3) incl3_reg <= incl2_reg;
        if (en4) incl4_reg <= incl3_reg;
    end

    // Stage 4: second minus first.
    logic signed [ddd_pkg::DIFF_W-1:0] diff_next, diff_reg;

    assign diff_next = $signed({1'b0, second_num}) - $signed({1'b0, first_num});

    always_ff @(posedge aclk) begin
        if (en4) diff_reg <= diff_next;
    end

    // Stage 5: inclusive step away from zero, then clamp to the output range.
    logic signed [ddd_pkg::DIFF_W-1:0] adj;
    logic signed [ddd_pkg::OUT_W-1:0]  result_next, result_reg;

    always_comb begin
        if (!incl4_reg) begin
            adj = diff_reg;
        end else if (diff_reg[ddd_pkg::DIFF_W-1]) begin
            adj = diff_reg - ddd_pkg::DIFF_W'(1);
        end else begin
            adj = diff_reg + ddd_pkg::DIFF_W'(1);
        end

        if (adj > ddd_pkg::OUT_MAX) begin
            result_next = ddd_pkg::OUT_MAX[ddd_pkg::OUT_W-1:0];
        end else if (adj < ddd_pkg::OUT_MIN) begin
            result_next = ddd_pkg::OUT_MIN[ddd_pkg::OUT_W-1:0];
        end else begin
            result_next = adj[ddd_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) result_reg <= result_next;
    end

    assign m_day_difference = result_reg;

endmodule

/* rtl/ddd_daynum.sv */
`timescale 1ns / 1ps
// Three-stage day number pipeline for one date.
// Depends on ddd_pkg.
module ddd_daynum (
    input  logic                           aclk,
    input  ddd_pkg::stage_en_t             en,
    input  logic [ddd_pkg::YEAR_W-1:0]     year,
    input  logic [ddd_pkg::MONTH_W-1:0]    month,
    input  logic [ddd_pkg::DAY_W-1:0]      day,
    output logic [ddd_pkg::DAYNUM_W-1:0]   day_num
);

    // stage 1: offset year, 365*n, reciprocal products
    logic [ddd_pkg::N_W-1:0]      n_next;
    logic [ddd_pkg::DAYNUM_W-1:0] n365_next;
    logic [ddd_pkg::PROD_W-1:0]   p100_next, p400_next, py_next;

    logic [ddd_pkg::N_W-1:0]      n_reg;
    logic [ddd_pkg::DAYNUM_W-1:0] n365_reg;
    logic [ddd_pkg::PROD_W-1:0]   p100_reg, p400_reg, py_reg;
    logic [ddd_pkg::YEAR_W-1:0]   year1_reg;
    logic [ddd_pkg::MONTH_W-1:0]  month1_reg;
    logic [ddd_pkg::DAY_W-1:0]    day1_reg;

    assign n_next    = ddd_pkg::N_W'(year) + ddd_pkg::YEAR_OFFSET;
    assign n365_next = ddd_pkg::DAYNUM_W'(n_next) * ddd_pkg::DAYS_PER_YEAR;
    assign p100_next = ddd_pkg::PROD_W'(n_next) * ddd_pkg::RECIP_100;
    assign p400_next = ddd_pkg::PROD_W'(n_next[ddd_pkg::N_W-1:2]) * ddd_pkg::RECIP_100;
    assign py_next   = ddd_pkg::PROD_W'(year) * ddd_pkg::RECIP_100;

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            n_reg      <= n_next;
            n365_reg   <= n365_next;
            p100_reg   <= p100_next;
            p400_reg   <= p400_next;
            py_reg     <= py_next;
            year1_reg  <= year;
            month1_reg <= month;
            day1_reg   <= day;
        end
    end

    // stage 2: whole-year days and leap flag
    logic [ddd_pkg::Q100_W-1:0]   q100, qy;
    logic [ddd_pkg::Q400_W-1:0]   q400;
    logic [2*ddd_pkg::Q100_W-1:0] qy_x100;
    logic                         century;
    logic [ddd_pkg::DAYNUM_W-1:0] years_next;
    logic                         leap_next;

    logic [ddd_pkg::DAYNUM_W-1:0] years_reg;
    logic                         leap_reg;
    logic [ddd_pkg::MONTH_W-1:0]  month2_reg;
    logic [ddd_pkg::DAY_W-1:0]    day2_reg;

    assign q100    = p100_reg[ddd_pkg::RECIP_SHIFT +: ddd_pkg::Q100_W];
    assign q400    = p400_reg[ddd_pkg::RECIP_SHIFT +: ddd_pkg::Q400_W];
    assign qy      = py_reg[ddd_pkg::RECIP_SHIFT +: ddd_pkg::Q100_W];
    assign qy_x100 = (2*ddd_pkg::Q100_W)'(qy) * ddd_pkg::CENTURY;
    assign century = ((2*ddd_pkg::Q100_W)'(year1_reg) == qy_x100);
    // divisible by 4, and either not a century or a century divisible by 400
    assign leap_next  = (year1_reg[1:0] == 2'b00) && (!century || (qy[1:0] == 2'b00));
    assign years_next = n365_reg + ddd_pkg::DAYNUM_W'(n_reg[ddd_pkg::N_W-1:2])
                      - ddd_pkg::DAYNUM_W'(q100) + ddd_pkg::DAYNUM_W'(q400);

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            years_reg  <= years_next;
            leap_reg   <= leap_next;
            month2_reg <= month1_reg;
            day2_reg   <= day1_reg;
        end
    end

    // stage 3: add month and day
    logic [ddd_pkg::DAYNUM_W-1:0] day_num_next;
    logic [ddd_pkg::DAYNUM_W-1:0] day_num_reg;
    logic                         leap_day;

    assign leap_day     = leap_reg && (month2_reg >= ddd_pkg::MARCH);
    assign day_num_next = years_reg
                        + ddd_pkg::DAYNUM_W'(ddd_pkg::days_before_month(month2_reg))
                        + ddd_pkg::DAYNUM_W'(leap_day)
                        + ddd_pkg::DAYNUM_W'(day2_reg);

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            day_num_reg <= day_num_next;
        end
    end

    assign day_num = day_num_reg;

endmodule
